/* rtl/core/window_regression_eta_top_defines.svh */
// Assertion helpers for the window regression block.
// Each helper is one labeled concurrent assertion clocked on the rising edge
// and switched off while the synchronous low-active reset is applied.
`ifndef WINDOW_REGRESSION_ETA_TOP_DEFINES_SVH
`define WINDOW_REGRESSION_ETA_TOP_DEFINES_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define WRE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the following edge.
`define WRE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/wre_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Window regression package
// Field widths, request codes and register indexes shared by the block and
// its channel interfaces.
// ----------------------------------------------------------------------------
package wre_pkg;

    // Field widths
    localparam int FUNC_W    = 2;
    localparam int PROBE_W   = 1;
    localparam int TS_W      = 32;
    localparam int TEMP_W    = 16;
    localparam int COUNT_W   = 7;
    localparam int RATE_W    = 32;
    localparam int TARGET_W  = 15;
    localparam int MINS_W    = 7;
    localparam int MAXW_W    = 20;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 20;

    // Working width of the exact regression arithmetic
    localparam int WIDE_W    = 128;
    localparam int MB_W      = 64;
    localparam int DIV_CNT_W = 7;

    // Request codes
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET0  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET1  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SMP  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WAIT = 2'd3;

    // Register reset values
    localparam logic [MINS_W-1:0] MIN_SMP_RST  = 7'd10;
    localparam logic [MAXW_W-1:0] MAX_WAIT_RST = 20'd86400;

    // Rate scale: 1/16 degree per second to 1/256 degree per minute
    localparam logic [MB_W-1:0] RATE_SCALE = 64'd960;

    // Saturation limits of the rate
    localparam logic [RATE_W-1:0] RATE_MAX = 32'h7FFF_FFFF;
    localparam logic [RATE_W-1:0] RATE_MIN = 32'h8000_0000;

endpackage

`default_nettype wire

/* rtl/core/wre_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Window regression request channel
// Valid/ready channel carrying one sample, query or clear request.
// ----------------------------------------------------------------------------
interface wre_in_if;
    import wre_pkg::*;

    logic                      valid;
    logic                      ready;
    logic        [FUNC_W-1:0]  func;
    logic        [PROBE_W-1:0] probe;
    logic        [TS_W-1:0]    timestamp;
    logic signed [TEMP_W-1:0]  temperature;

    modport source (output valid, func, probe, timestamp, temperature, input ready);
    modport sink   (input valid, func, probe, timestamp, temperature, output ready);
endinterface

`default_nettype wire

/* rtl/core/wre_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Window regression result channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface wre_out_if;
    import wre_pkg::*;

    logic                      valid;
    logic                      ready;
    logic        [PROBE_W-1:0] out_probe;
    logic signed [TEMP_W-1:0]  latest_temp;
    logic        [COUNT_W-1:0] sample_count;
    logic signed [RATE_W-1:0]  rate_per_min;
    logic        [TS_W-1:0]    est_done_time;

    modport source (output valid, out_probe, latest_temp, sample_count, rate_per_min,
                    est_done_time, input ready);
    modport sink   (input valid, out_probe, latest_temp, sample_count, rate_per_min,
                    est_done_time, output ready);
endinterface

`default_nettype wire

/* rtl/core/window_regression_eta_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Window regression ETA
// Per-probe rolling window of (timestamp, temperature) samples with an exact
// least-squares slope and a time-to-target estimate.
// ----------------------------------------------------------------------------
// Each request takes one probe; a sample request with a nonzero time stores
// into that probe's ring, a clear request empties it, a query only reads.
// Every request gives one result. The block handles one request at a time
// and drops ready until the result is parked in the output register, which
// then waits for the sink while the next request is taken. A request makes
// one memory read and two passes through a 33x33 multiplier per window
// sample, then multiplies in the shift-add unit by n twice, sum of x twice,
// 960, and for an estimate the temperature gap and the wait limit, and
// divides in the restoring divider for the rate and, for an estimate, for
// the wait. When fewer than min_samples are held, the regression is skipped.
// ----------------------------------------------------------------------------
`include "window_regression_eta_top_defines.svh"

module window_regression_eta_top #(
    parameter int WINDOW_DEPTH = 64,
    parameter int PROBE_COUNT  = 2
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    wre_in_if.sink                       i_in,
    wre_out_if.source                    o_out,
    input  wire                          i_cfg_we,
    input  wire [wre_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [wre_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import wre_pkg::*;

    localparam int SW     = $clog2(WINDOW_DEPTH);
    localparam int CW     = $clog2(WINDOW_DEPTH + 1);
    localparam int MD     = PROBE_COUNT * WINDOW_DEPTH;
    localparam int AW     = (MD > 1) ? $clog2(MD) : 1;
    localparam int PIW    = (PROBE_COUNT > 1) ? $clog2(PROBE_COUNT) : 1;
    localparam int SX_W   = TS_W + CW;
    localparam int SY_W   = TEMP_W + CW;
    localparam int SXY_W  = TS_W + TEMP_W + CW;
    localparam int SXX_W  = 2 * TS_W + CW;
    localparam int MUL_W  = 2 * (TS_W + 1);
    localparam int DELT_W = TEMP_W + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_LAT, S_LAT2, S_T0, S_RD, S_X, S_M1, S_M2, S_M3,
        S_NUM2, S_NUM3, S_DEN2, S_DEN3, S_RATE1, S_RATE2, S_EST1, S_EST2,
        S_EST3, S_MUL, S_DIV, S_DONE
    } t_state;

    // Sample memories
    logic        [TS_W-1:0]   time_mem [MD];
    logic signed [TEMP_W-1:0] temp_mem [MD];
    logic        [TS_W-1:0]   rd_time;
    logic signed [TEMP_W-1:0] rd_temp;
    logic        [AW-1:0]     rd_addr;
    logic        [AW-1:0]     wr_addr;
    logic                     wr_en;

    // Control and configuration
    t_state                   r_state, r_ret;
    logic        [SW-1:0]     r_wp   [PROBE_COUNT];
    logic        [CW-1:0]     r_fill [PROBE_COUNT];
    logic        [TARGET_W-1:0] r_target0, r_target1;
    logic        [MINS_W-1:0] r_min;
    logic        [MAXW_W-1:0] r_maxw;
    logic                     r_out_valid;

    // Request context
    logic        [PROBE_W-1:0] r_probe;
    logic        [PIW-1:0]    r_pidx;
    logic        [TS_W-1:0]   r_ts;
    logic        [CW-1:0]     r_n, r_cnt;
    logic        [SW-1:0]     r_idx;
    logic        [TS_W-1:0]   r_t0, r_x;
    logic signed [TEMP_W-1:0] r_y, r_latest;
    logic signed [MUL_W-1:0]  r_prod;
    logic        [SX_W-1:0]   r_sx;
    logic signed [SY_W-1:0]   r_sy;
    logic signed [SXY_W-1:0]  r_sxy;
    logic        [SXX_W-1:0]  r_sxx;
    logic        [WIDE_W-1:0] r_t1, r_num, r_den;
    logic                     r_neg;
    logic        [RATE_W-1:0] r_rate;
    logic        [TS_W-1:0]   r_est;

    // Shift-add multiplier and restoring divider state
    logic        [WIDE_W-1:0] r_ma, r_macc;
    logic        [MB_W-1:0]   r_mb;
    logic        [WIDE_W-1:0] r_rem, r_dvd, r_dvs;
    logic        [DIV_CNT_W-1:0] r_dcnt;

    // Output register
    logic        [PROBE_W-1:0] r_o_probe;
    logic signed [TEMP_W-1:0] r_o_latest;
    logic        [COUNT_W-1:0] r_o_count;
    logic        [RATE_W-1:0] r_o_rate;
    logic        [TS_W-1:0]   r_o_est;

    // Combinational helpers
    logic                     in_acc, probe_ok;
    logic        [PIW-1:0]    in_pidx;
    logic        [SW-1:0]     cur_wp, lat_slot, idx_inc;
    logic        [CW-1:0]     cur_fill;
    logic        [AW-1:0]     in_base, base;
    logic signed [TS_W:0]     mul_a, mul_b;
    logic signed [MUL_W-1:0]  mul_p;
    logic        [WIDE_W-1:0] rem_sh, rem_nx, neg_macc;
    logic                     rem_ge;
    logic        [TARGET_W-1:0] tgt;
    logic signed [DELT_W-1:0] delta;
    logic                     est_ok;
    logic        [WIDE_W-1:0] prod_sxy, prod_sy, sxx_wide;
    logic        [SXY_W-1:0]  sxy_nx;

    assign in_acc   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign probe_ok = (int'(i_in.probe) < PROBE_COUNT);
    assign in_pidx  = PIW'(i_in.probe);
    assign in_base  = AW'(int'(i_in.probe) * WINDOW_DEPTH);
    assign base     = AW'(int'(r_probe) * WINDOW_DEPTH);
    assign cur_wp   = r_wp[r_pidx];
    assign cur_fill = r_fill[r_pidx];
    assign lat_slot = (cur_wp == '0) ? SW'(WINDOW_DEPTH - 1) : cur_wp - 1'b1;
    assign idx_inc  = (r_idx == SW'(WINDOW_DEPTH - 1)) ? '0 : r_idx + 1'b1;

    // Pick the memory read address: newest slot first, then the walk
    assign rd_addr = (r_state == S_LAT) ? base + AW'(lat_slot) : base + AW'(r_idx);

    // Store a sample request with a valid time
    assign wr_en   = in_acc && probe_ok && (i_in.func == FUNC_ADD) && (i_in.timestamp != '0);
    assign wr_addr = in_base + AW'(r_wp[in_pidx]);

    // Per-sample multiplier: x*x then x*y
    assign mul_a = $signed({1'b0, r_x});
    assign mul_b = (r_state == S_M1) ? $signed({1'b0, r_x})
                                     : $signed({{(TS_W+1-TEMP_W){r_y[TEMP_W-1]}}, r_y});
    assign mul_p = mul_a * mul_b;

    // Restoring divider step
    assign rem_sh = {r_rem[WIDE_W-2:0], r_dvd[WIDE_W-1]};
    assign rem_ge = (rem_sh >= r_dvs);
    assign rem_nx = rem_ge ? rem_sh - r_dvs : rem_sh;

    assign neg_macc = '0 - r_macc;
    assign prod_sxy = {{(WIDE_W-SXY_W){r_sxy[SXY_W-1]}}, r_sxy};
    assign prod_sy  = {{(WIDE_W-SY_W){r_sy[SY_W-1]}}, r_sy};
    assign sxx_wide = WIDE_W'(r_sxx);
    assign sxy_nx   = r_sxy + r_prod[SXY_W-1:0];

    // Estimate gate and temperature gap
    assign tgt    = r_probe[0] ? r_target1 : r_target0;
    assign delta  = $signed({2'b00, tgt}) - $signed({r_latest[TEMP_W-1], r_latest});
    assign est_ok = (tgt != '0) && (delta > 0) && !r_num[WIDE_W-1] && (r_num != '0)
                    && (r_ts != '0);

    // Hold the sample memories
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            time_mem[wr_addr] <= i_in.timestamp;
            temp_mem[wr_addr] <= i_in.temperature;
        end
        rd_time <= time_mem[rd_addr];
        rd_temp <= temp_mem[rd_addr];
    end

    // Sequencer, ring pointers, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_out_valid <= 1'b0;
            r_target0   <= '0;
            r_target1   <= '0;
            r_min       <= MIN_SMP_RST;
            r_maxw      <= MAX_WAIT_RST;
            for (int p = 0; p < PROBE_COUNT; p++) begin
                r_wp[p]   <= '0;
                r_fill[p] <= '0;
            end
        end else begin
            // Take configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TARGET0:  r_target0 <= i_cfg_data[TARGET_W-1:0];
                    CFG_TARGET1:  r_target1 <= i_cfg_data[TARGET_W-1:0];
                    CFG_MIN_SMP:  r_min     <= i_cfg_data[MINS_W-1:0];
                    CFG_MAX_WAIT: r_maxw    <= i_cfg_data[MAXW_W-1:0];
                    default: ;
                endcase
            end

            // Drop the result once taken
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_probe  <= i_in.probe;
                        r_pidx   <= in_pidx;
                        r_ts     <= i_in.timestamp;
                        r_rate   <= '0;
                        r_est    <= '0;
                        r_latest <= '0;
                        r_n      <= '0;
                        if (!probe_ok) begin
                            r_state <= S_DONE;
                        end else begin
                            if (wr_en) begin
                                r_wp[in_pidx] <= (r_wp[in_pidx] == SW'(WINDOW_DEPTH - 1))
                                                 ? '0 : r_wp[in_pidx] + 1'b1;
                                if (r_fill[in_pidx] != CW'(WINDOW_DEPTH)) begin
                                    r_fill[in_pidx] <= r_fill[in_pidx] + 1'b1;
                                end
                            end else if (i_in.func == FUNC_CLEAR) begin
                                r_wp[in_pidx]   <= '0;
                                r_fill[in_pidx] <= '0;
                            end
                            r_state <= S_LAT;
                        end
                    end
                end
                S_LAT: begin
                    r_n     <= cur_fill;
                    r_idx   <= (cur_fill == CW'(WINDOW_DEPTH)) ? cur_wp : '0;
                    r_state <= S_LAT2;
                end
                S_LAT2: begin
                    r_latest <= (r_n != '0) ? rd_temp : '0;
                    if (int'(r_n) < int'(r_min)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_T0;
                    end
                end
                S_T0: begin
                    r_t0  <= rd_time;
                    r_cnt <= '0;
                    r_sx  <= '0;
                    r_sy  <= '0;
                    r_sxy <= '0;
                    r_sxx <= '0;
                    if (r_n == '0) begin
                        r_ma    <= '0;
                        r_mb    <= '0;
                        r_macc  <= '0;
                        r_ret   <= S_NUM2;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_X;
                end
                S_X: begin
                    r_x     <= rd_time - r_t0;
                    r_y     <= rd_temp;
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_prod  <= mul_p;
                    r_sx    <= r_sx + SX_W'(r_x);
                    r_sy    <= r_sy + {{(SY_W-TEMP_W){r_y[TEMP_W-1]}}, r_y};
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_sxx   <= r_sxx + SXX_W'(r_prod[2*TS_W-1:0]);
                    r_prod  <= mul_p;
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_sxy <= sxy_nx;
                    r_cnt <= r_cnt + 1'b1;
                    r_idx <= idx_inc;
                    if (r_cnt + 1'b1 == r_n) begin
                        // n * sum(x*y)
                        r_ma    <= {{(WIDE_W-SXY_W){sxy_nx[SXY_W-1]}}, sxy_nx};
                        r_mb    <= MB_W'(r_n);
                        r_macc  <= '0;
                        r_ret   <= S_NUM2;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_NUM2: begin
                    // sum(x) * sum(y)
                    r_t1    <= r_macc;
                    r_ma    <= prod_sy;
                    r_mb    <= MB_W'(r_sx);
                    r_macc  <= '0;
                    r_ret   <= S_NUM3;
                    r_state <= S_MUL;
                end
                S_NUM3: begin
                    // n * sum(x*x)
                    r_num   <= r_t1 - r_macc;
                    r_ma    <= sxx_wide;
                    r_mb    <= MB_W'(r_n);
                    r_macc  <= '0;
                    r_ret   <= S_DEN2;
                    r_state <= S_MUL;
                end
                S_DEN2: begin
                    // sum(x) squared
                    r_t1    <= r_macc;
                    r_ma    <= WIDE_W'(r_sx);
                    r_mb    <= MB_W'(r_sx);
                    r_macc  <= '0;
                    r_ret   <= S_DEN3;
                    r_state <= S_MUL;
                end
                S_DEN3: begin
                    r_den <= r_t1 - r_macc;
                    if (r_t1 == r_macc) begin
                        r_state <= S_DONE;
                    end else begin
                        r_ma    <= r_num;
                        r_mb    <= RATE_SCALE;
                        r_macc  <= '0;
                        r_ret   <= S_RATE1;
                        r_state <= S_MUL;
                    end
                end
                S_RATE1: begin
                    // Divide the magnitude of 960*num by den
                    r_neg   <= r_macc[WIDE_W-1];
                    r_dvd   <= r_macc[WIDE_W-1] ? neg_macc : r_macc;
                    r_dvs   <= r_den;
                    r_rem   <= '0;
                    r_dcnt  <= '0;
                    r_ret   <= S_RATE2;
                    r_state <= S_DIV;
                end
                S_RATE2: begin
                    // Saturate the rate to 32 bits signed
                    if (r_neg) begin
                        if ((r_dvd[WIDE_W-1:RATE_W] != '0) || (r_dvd[RATE_W-1:0] > RATE_MIN)) begin
                            r_rate <= RATE_MIN;
                        end else begin
                            r_rate <= '0 - r_dvd[RATE_W-1:0];
                        end
                    end else begin
                        if (r_dvd[WIDE_W-1:RATE_W-1] != '0) begin
                            r_rate <= RATE_MAX;
                        end else begin
                            r_rate <= r_dvd[RATE_W-1:0];
                        end
                    end
                    if (est_ok) begin
                        // Time needed scaled by num: delta * den
                        r_ma    <= r_den;
                        r_mb    <= MB_W'(delta[DELT_W-2:0]);
                        r_macc  <= '0;
                        r_ret   <= S_EST1;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_EST1: begin
                    // Wait limit scaled by num
                    r_t1    <= r_macc;
                    r_ma    <= r_num;
                    r_mb    <= MB_W'(r_maxw);
                    r_macc  <= '0;
                    r_ret   <= S_EST2;
                    r_state <= S_MUL;
                end
                S_EST2: begin
                    if (r_t1 <= r_macc) begin
                        r_dvd   <= r_t1;
                        r_dvs   <= r_num;
                        r_rem   <= '0;
                        r_dcnt  <= '0;
                        r_ret   <= S_EST3;
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_EST3: begin
                    r_est   <= r_ts + r_dvd[TS_W-1:0];
                    r_state <= S_DONE;
                end
                S_MUL: begin
                    // Shift-add one multiplier bit per cycle
                    if (r_mb == '0) begin
                        r_state <= r_ret;
                    end else begin
                        if (r_mb[0]) begin
                            r_macc <= r_macc + r_ma;
                        end
                        r_ma <= {r_ma[WIDE_W-2:0], 1'b0};
                        r_mb <= {1'b0, r_mb[MB_W-1:1]};
                    end
                end
                S_DIV: begin
                    // One quotient bit per cycle
                    r_rem  <= rem_nx;
                    r_dvd  <= {r_dvd[WIDE_W-2:0], rem_ge};
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == '1) begin
                        r_state <= r_ret;
                    end
                end
                S_DONE: begin
                    // Park the result when the output register is free
                    if (!r_out_valid || o_out.ready) begin
                        r_o_probe   <= r_probe;
                        r_o_latest  <= r_latest;
                        r_o_count   <= COUNT_W'(r_n);
                        r_o_rate    <= r_rate;
                        r_o_est     <= r_est;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_probe     = r_o_probe;
    assign o_out.latest_temp   = r_o_latest;
    assign o_out.sample_count  = r_o_count;
    assign o_out.rate_per_min  = r_o_rate;
    assign o_out.est_done_time = r_o_est;

    // Checks
    `WRE_ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n, (i_in.valid && i_in.ready), (r_state != S_IDLE), "request accepted but sequencer stayed idle")
    `WRE_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, (r_state == S_LAT), (int'(cur_fill) <= WINDOW_DEPTH), "fill count beyond window depth")
    `WRE_ASSERT_NXT(a_result_parked, i_clk, i_rst_n, ((r_state == S_DONE) && (!r_out_valid || o_out.ready)), (r_out_valid && (r_state == S_IDLE)), "finished result not parked")

endmodule

`default_nettype wire

/* tb/sv/tb_window_regression_eta_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window regression ETA testbench
// Drives sample, query and clear requests through the request channel under
// random idling. An in-bench slope and estimate predictor forms the expected
// result of every accepted request. The result channel is checked against it
// in order, on every field.
// ----------------------------------------------------------------------------
module tb_window_regression_eta_top;
    import wre_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_RSVD = 2'd3;
    localparam int RING_DEPTH = 64;

    typedef struct {
        logic [FUNC_W-1:0]  func;
        logic [PROBE_W-1:0] probe;
        logic [TS_W-1:0]    stamp;
        logic signed [TEMP_W-1:0] temp;
    } probe_req_t;

    typedef struct {
        logic [PROBE_W-1:0]       probe;
        logic signed [TEMP_W-1:0] latest;
        logic [COUNT_W-1:0]       count;
        logic signed [RATE_W-1:0] rate;
        logic [TS_W-1:0]          eta;
    } probe_res_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    wre_in_if  req_if ();
    wre_out_if res_if ();

    window_regression_eta_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (req_if),
        .o_out       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor state
    logic [TS_W-1:0]   stamp_ring [2][RING_DEPTH];
    logic signed [TEMP_W-1:0] temp_ring [2][RING_DEPTH];
    int unsigned       ring_head [2];
    int unsigned       ring_fill [2];
    int unsigned       target_cfg [2];
    int unsigned       min_fill_cfg;
    int unsigned       wait_limit_cfg;

    probe_req_t pending_reqs [$];
    probe_res_t expected_results [$];
    probe_res_t cur_req_res;
    probe_req_t cur_req;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         mismatches = 0;

    // Feed one request into the window model and return its result
    function automatic probe_res_t forecast(probe_req_t rq);
        probe_res_t r;
        int unsigned p, n, oldest, idx, i, hd;
        logic [31:0] t0, x;
        logic signed [127:0] sx, sy, sxy, sxx, num, den, prod, y, need, lim, tgt_gap;
        logic [127:0] mag, quo;
        int signed latest, tgt;
        p = rq.probe;
        r.probe = rq.probe;
        r.latest = '0;
        r.count = '0;
        r.rate = '0;
        r.eta = '0;
        if (rq.func == FUNC_ADD && rq.stamp != 0) begin
            stamp_ring[p][ring_head[p]] = rq.stamp;
            temp_ring[p][ring_head[p]] = rq.temp;
            ring_head[p] = (ring_head[p] + 1) % RING_DEPTH;
            if (ring_fill[p] < RING_DEPTH) ring_fill[p]++;
        end else if (rq.func == FUNC_CLEAR) begin
            ring_head[p] = 0;
            ring_fill[p] = 0;
        end
        n = ring_fill[p];
        latest = 0;
        if (n != 0) begin
            hd = (ring_head[p] == 0) ? RING_DEPTH - 1 : ring_head[p] - 1;
            latest = temp_ring[p][hd];
        end
        tgt = target_cfg[p];
        r.latest = latest[15:0];
        r.count = n[6:0];
        if (n < min_fill_cfg) return r;

        // Sums over the window, timestamps relative to the oldest sample
        oldest = (n < RING_DEPTH) ? 0 : ring_head[p];
        t0 = stamp_ring[p][oldest];
        sx = 0; sy = 0; sxy = 0; sxx = 0;
        for (i = 0; i < n; i++) begin
            idx = (oldest + i) % RING_DEPTH;
            x = stamp_ring[p][idx] - t0;
            y = temp_ring[p][idx];
            sx = sx + $signed({96'd0, x});
            sy = sy + y;
            sxy = sxy + $signed({96'd0, x}) * y;
            sxx = sxx + $signed({96'd0, x}) * $signed({96'd0, x});
        end
        num = $signed(128'(n)) * sxy - sx * sy;
        den = $signed(128'(n)) * sxx - sx * sx;
        if (den == 0) return r;

        // Rate: truncate toward zero, saturate to 32 bits
        prod = num * 128'sd960;
        mag = (prod < 0) ? $unsigned(-prod) : $unsigned(prod);
        quo = mag / $unsigned(den);
        if (prod < 0) begin
            r.rate = (quo > 128'h8000_0000) ? RATE_MIN : -quo[31:0];
        end else begin
            r.rate = (quo > 128'h7FFF_FFFF) ? RATE_MAX : quo[31:0];
        end

        // Estimate only for a rising probe below a set target, within the limit
        if (tgt != 0 && latest < tgt && num > 0 && rq.stamp != 0) begin
            tgt_gap = tgt - latest;
            need = tgt_gap * den;
            lim = $signed(128'(wait_limit_cfg)) * num;
            if (need <= lim) begin
                quo = $unsigned(need) / $unsigned(num);
                r.eta = rq.stamp + quo[31:0];
            end
        end
        return r;
    endfunction

    // Clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        req_if.valid = 1'b0;
        req_if.func = '0;
        req_if.probe = '0;
        req_if.timestamp = '0;
        req_if.temperature = '0;
        res_if.ready = 1'b0;
    end

    // Request driver: predict on acceptance, then present the next request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                expected_results.push_back(forecast(cur_req));
            end
            if (!req_if.valid || req_if.ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_req = pending_reqs.pop_front();
                    req_if.valid <= 1'b1;
                    req_if.func <= cur_req.func;
                    req_if.probe <= cur_req.probe;
                    req_if.timestamp <= cur_req.stamp;
                    req_if.temperature <= cur_req.temp;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: stall at random, compare with the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result for probe %0d",
                                                   res_if.out_probe);
                end else begin
                    cur_req_res = expected_results.pop_front();
                    if (res_if.out_probe !== cur_req_res.probe ||
                        res_if.latest_temp !== cur_req_res.latest ||
                        res_if.sample_count !== cur_req_res.count ||
                        res_if.rate_per_min !== cur_req_res.rate ||
                        res_if.est_done_time !== cur_req_res.eta) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result error: exp probe %0d temp %0d cnt %0d rate %0d eta %0d",
                                     cur_req_res.probe, cur_req_res.latest, cur_req_res.count,
                                     cur_req_res.rate, cur_req_res.eta);
                            $display("              got probe %0d temp %0d cnt %0d rate %0d eta %0d",
                                     res_if.out_probe, res_if.latest_temp, res_if.sample_count,
                                     res_if.rate_per_min, res_if.est_done_time);
                        end
                    end
                end
            end
            res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Write one register and mirror it in the predictor
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[CFG_DAT_W-1:0];
        case (idx)
            CFG_TARGET0:  target_cfg[0] = val & 32'h7FFF;
            CFG_TARGET1:  target_cfg[1] = val & 32'h7FFF;
            CFG_MIN_SMP:  min_fill_cfg = val & 32'h7F;
            CFG_MAX_WAIT: wait_limit_cfg = val & 32'hF_FFFF;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(int unsigned t0, int unsigned t1, int unsigned mins,
                            int unsigned maxw);
        write_reg(CFG_TARGET0, t0);
        write_reg(CFG_TARGET1, t1);
        write_reg(CFG_MIN_SMP, mins);
        write_reg(CFG_MAX_WAIT, maxw);
    endtask

    task automatic queue_req(logic [FUNC_W-1:0] f, logic p, logic [31:0] ts, int tmp);
        probe_req_t rq;
        rq.func = f;
        rq.probe = p;
        rq.stamp = ts;
        rq.temp = tmp[15:0];
        pending_reqs.push_back(rq);
    endtask

    // Hold until every request is sent and every result is back
    task automatic drain();
        while (pending_reqs.size() != 0 || req_if.valid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Mostly rising ramps per probe, with clears, queries and noise mixed in
    task automatic queue_random(int count);
        logic [31:0] clock_now [2];
        int level [2];
        int k, r, p;
        clock_now[0] = $urandom;
        clock_now[1] = $urandom_range(1000, 100000);
        level[0] = $urandom_range(0, 1600) - 400;
        level[1] = $urandom_range(0, 1600) - 400;
        for (k = 0; k < count; k++) begin
            r = $urandom_range(99);
            p = $urandom_range(1);
            if (r < 5) begin
                queue_req(FUNC_CLEAR, p, $urandom, $urandom);
                level[p] = $urandom_range(0, 1600) - 400;
            end else if (r < 15) begin
                queue_req(($urandom_range(1) ? FUNC_QUERY : FUNC_RSVD), p,
                          ($urandom_range(9) == 0) ? 32'd0 : clock_now[p], $urandom);
            end else if (r < 22) begin
                queue_req(FUNC_ADD, p, ($urandom_range(3) == 0) ? 32'd0 : $urandom, $urandom);
            end else begin
                clock_now[p] = clock_now[p] + $urandom_range(0, 900);
                level[p] = level[p] + $urandom_range(0, 40) - 10;
                if (level[p] > 32767) level[p] = 32767;
                if (level[p] < -32768) level[p] = -32768;
                queue_req(FUNC_ADD, p, clock_now[p], level[p]);
            end
        end
    endtask

    // Main sequence
    initial begin
        int k;
        for (k = 0; k < 2; k++) begin
            ring_head[k] = 0;
            ring_fill[k] = 0;
        end
        target_cfg[0] = 0;
        target_cfg[1] = 0;
        min_fill_cfg = MIN_SMP_RST;
        wait_limit_cfg = MAX_WAIT_RST;
        send_idle_pct = 15;
        recv_idle_pct = 79;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, empty window, missing time, flat and falling slopes
        set_regs(800, 32767, 2, 86400);
        queue_req(FUNC_QUERY, 0, 0, 0);
        queue_req(FUNC_ADD, 0, 0, 100);
        queue_req(FUNC_ADD, 0, 32'd1, -32768);
        queue_req(FUNC_ADD, 0, 32'd1, 32767);
        queue_req(FUNC_QUERY, 0, 32'd5, 0);
        queue_req(FUNC_CLEAR, 0, 32'd5, 0);
        queue_req(FUNC_ADD, 0, 32'hFFFF_FFF0, 100);
        queue_req(FUNC_ADD, 0, 32'hFFFF_FFFF, 200);
        queue_req(FUNC_ADD, 0, 32'h0000_0010, 300);
        queue_req(FUNC_QUERY, 0, 0, 0);
        queue_req(FUNC_RSVD, 0, 32'h0000_0020, -1);
        queue_req(FUNC_ADD, 0, 32'h0000_0030, 900);
        queue_req(FUNC_ADD, 1, 32'd1000, 500);
        queue_req(FUNC_ADD, 1, 32'd1060, 400);
        queue_req(FUNC_ADD, 1, 32'd1120, 300);
        queue_req(FUNC_ADD, 1, 32'd2000, 32767);
        queue_req(FUNC_ADD, 1, 32'd2001, -32768);
        queue_req(FUNC_CLEAR, 1, 0, 0);
        queue_req(FUNC_ADD, 1, 32'd10, 0);
        queue_req(FUNC_ADD, 1, 32'd11, 1);
        queue_req(FUNC_QUERY, 1, 32'hFFFF_FFFF, 0);
        drain();

        // Random phases through several register settings and idling mixes
        set_regs($urandom_range(0, 3000), $urandom_range(1, 32767), 10, 1048575);
        queue_random(350);
        drain();
        send_idle_pct = 79;
        recv_idle_pct = 15;
        set_regs(0, $urandom_range(500, 4000), 64, 0);
        queue_random(300);
        drain();
        set_regs($urandom_range(500, 4000), $urandom_range(500, 4000), 2, $urandom_range(1, 1048575));
        queue_random(80);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_regs($urandom_range(1000, 3000), $urandom_range(1000, 3000), $urandom_range(2, 64),
                 86400);
        queue_random(300);
        drain();

        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("window_regression_eta_top: match");
        end else begin
            $display("window_regression_eta_top: mismatch");
        end
        $finish;
    end

    // Timeout
    initial begin
        #40_000_000;
        $display("window_regression_eta_top: mismatch");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/wre_pkg.sv
rtl/core/wre_in_if.sv
rtl/core/wre_out_if.sv
rtl/core/window_regression_eta_top.sv
tb/sv/tb_window_regression_eta_top.sv
